### hdl/aes256_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes256_pkg
// types, constants and byte functions shared by the cipher core and the bench
// ----------------------------------------------------------------------------
package aes256_pkg;

   typedef struct packed {
      logic        req_type;
      logic [63:0] block_high;
      logic [63:0] block_low;
   } req_word_type;

   typedef struct packed {
      logic [63:0] out_high;
      logic [63:0] out_low;
   } rsp_word_type;

   localparam logic [1:0] CSR_KEY_0_7   = 2'd0;
   localparam logic [1:0] CSR_KEY_8_15  = 2'd1;
   localparam logic [1:0] CSR_KEY_16_23 = 2'd2;
   localparam logic [1:0] CSR_KEY_24_31 = 2'd3;

   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   localparam int NUM_ROUND_KEYS = 15;
   localparam int RK_ADDR_W      = 4;

   localparam logic [7:0] GF_POLY = 8'h1b;
   localparam logic [7:0] RCON_1  = 8'h01;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

   localparam logic [7:0] INV_SBOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
   endfunction

   // byte i of a 128-bit word sits in bits 127-8i downto 120-8i
   function automatic logic [7:0] get_byte(input logic [127:0] s, input int i);
      get_byte = s[127-8*i -: 8];
   endfunction

   function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
      logic [127:0] o;
      int c, r;
      o = '0;
      for (c = 0; c < 4; c++) begin
         for (r = 0; r < 4; r++) begin
            if (inv) begin
               o[127-8*(((c+r)&3)*4+r) -: 8] = INV_SBOX[get_byte(s, c*4+r)];
            end else begin
               o[127-8*(c*4+r) -: 8] = SBOX[get_byte(s, ((c+r)&3)*4+r)];
            end
         end
      end
      sub_shift = o;
   endfunction

   function automatic logic [127:0] mix_fwd(input logic [127:0] s);
      logic [127:0] o;
      logic [7:0] a0, a1, a2, a3;
      int c;
      o = '0;
      for (c = 0; c < 4; c++) begin
         a0 = get_byte(s, c*4);
         a1 = get_byte(s, c*4+1);
         a2 = get_byte(s, c*4+2);
         a3 = get_byte(s, c*4+3);
         o[127-8*(c*4)   -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
         o[127-8*(c*4+1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
         o[127-8*(c*4+2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
         o[127-8*(c*4+3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
      mix_fwd = o;
   endfunction

   function automatic logic [127:0] mix_inv(input logic [127:0] s);
      logic [127:0] o;
      logic [7:0] a [4];
      logic [7:0] x2 [4];
      logic [7:0] x4 [4];
      logic [7:0] x8 [4];
      logic [7:0] m9 [4];
      logic [7:0] mb [4];
      logic [7:0] md [4];
      logic [7:0] me [4];
      int c, k;
      o = '0;
      for (c = 0; c < 4; c++) begin
         for (k = 0; k < 4; k++) begin
            a[k]  = get_byte(s, c*4+k);
            x2[k] = xtime(a[k]);
            x4[k] = xtime(x2[k]);
            x8[k] = xtime(x4[k]);
            m9[k] = x8[k] ^ a[k];
            mb[k] = x8[k] ^ x2[k] ^ a[k];
            md[k] = x8[k] ^ x4[k] ^ a[k];
            me[k] = x8[k] ^ x4[k] ^ x2[k];
         end
         o[127-8*(c*4)   -: 8] = me[0] ^ mb[1] ^ md[2] ^ m9[3];
         o[127-8*(c*4+1) -: 8] = m9[0] ^ me[1] ^ mb[2] ^ md[3];
         o[127-8*(c*4+2) -: 8] = md[0] ^ m9[1] ^ me[2] ^ mb[3];
         o[127-8*(c*4+3) -: 8] = mb[0] ^ md[1] ^ m9[2] ^ me[3];
      end
      mix_inv = o;
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

endpackage

### hdl/aes256_block_cipher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes256_block_cipher_core
// aes-256 ecb encrypt/decrypt with round keys held in a 15-entry ram
// a word is accepted only in idle, so a new word waits until the previous one is done;
// one round per cycle through a shared round unit, one round key read per cycle.
// a result word not yet taken holds the next word in its last round.
// reset and every key write run the key expansion, one key word per cycle;
// no word is accepted while it runs (csr writes still taken).
// ----------------------------------------------------------------------------
module aes256_block_cipher_core
   import aes256_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [63:0]  csr_data
);

   typedef enum logic [3:0] {
      ST_EXPAND = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_PRIME  = 4'b0100,
      ST_ROUND  = 4'b1000
   } state_type;

   state_type      state_ff, state_in;
   logic [255:0]   key_ff, key_in;
   logic [255:0]   win_ff, win_in;
   logic [5:0]     wcnt_ff, wcnt_in;
   logic [7:0]     rcon_ff, rcon_in;
   logic           rerun_ff, rerun_in;
   logic [3:0]     rnd_ff, rnd_in;
   logic           dec_ff, dec_in;
   logic [127:0]   st_ff, st_in;
   logic           out_v_ff, out_v_in;
   rsp_word_type   out_ff, out_in;

   logic                 wr_en;
   logic [RK_ADDR_W-1:0] wr_addr;
   logic [127:0]         wr_data;
   logic [RK_ADDR_W-1:0] rd_addr;
   logic [127:0]         rk;
   logic [31:0]          t, nw;
   logic [127:0]         ss, rnd_out;
   logic                 last;

   aes256_ram #(.Width(128), .Depth(NUM_ROUND_KEYS)) u_rk_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rk)
   );

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE) && !rerun_ff;
   assign rsp_valid = out_v_ff;
   assign rsp_word  = out_ff;

   // key schedule: win_ff holds the last eight words, one new word per cycle
   always_comb begin
      t = win_ff[31:0];
      if (wcnt_ff[2:0] == 3'd0) begin
         t = sub_word({t[23:0], t[31:24]}) ^ {rcon_ff, 24'h0};
      end else if (wcnt_ff[2:0] == 3'd4) begin
         t = sub_word(t);
      end
      nw = win_ff[255:224] ^ t;
   end

   assign last = dec_ff ? (rnd_ff == 4'd0) : (rnd_ff == 4'd14);

   always_comb begin
      ss = sub_shift(st_ff, dec_ff);
      if (dec_ff) begin
         rnd_out = (rnd_ff == 4'd0) ? (ss ^ rk) : mix_inv(ss ^ rk);
      end else begin
         rnd_out = (rnd_ff == 4'd14) ? (ss ^ rk) : (mix_fwd(ss) ^ rk);
      end
   end

   always_comb begin
      state_in = state_ff;
      key_in   = key_ff;
      win_in   = win_ff;
      wcnt_in  = wcnt_ff;
      rcon_in  = rcon_ff;
      rerun_in = rerun_ff;
      rnd_in   = rnd_ff;
      dec_in   = dec_ff;
      st_in    = st_ff;
      out_v_in = out_v_ff;
      out_in   = out_ff;
      wr_en    = 1'b0;
      wr_addr  = wcnt_ff[5:2];
      wr_data  = win_ff[255:128];
      rd_addr  = rnd_ff;

      if (out_v_ff && rsp_ready) begin
         out_v_in = 1'b0;
      end

      if (csr_valid) begin
         unique case (csr_index)
            CSR_KEY_0_7:   key_in[255:192] = csr_data;
            CSR_KEY_8_15:  key_in[191:128] = csr_data;
            CSR_KEY_16_23: key_in[127:64]  = csr_data;
            CSR_KEY_24_31: key_in[63:0]    = csr_data;
            default:       key_in = key_ff;
         endcase
         rerun_in = 1'b1;
      end

      unique case (state_ff)
         ST_EXPAND: begin
            // wcnt counts words 8..59; at each multiple of 4 the top four
            // window words form round key wcnt/4-2
            if (wcnt_ff == 6'd60) begin
               wr_en    = 1'b1;
               wr_addr  = 4'd13;
               wr_data  = win_ff[255:128];
               wcnt_in  = 6'd61;
            end else if (wcnt_ff == 6'd61) begin
               wr_en    = 1'b1;
               wr_addr  = 4'd14;
               wr_data  = win_ff[127:0];
               state_in = ST_IDLE;
            end else begin
               if (wcnt_ff[1:0] == 2'd0) begin
                  wr_en   = 1'b1;
                  wr_addr = wcnt_ff[5:2] - 4'd2;
               end
               win_in  = {win_ff[223:0], nw};
               wcnt_in = wcnt_ff + 6'd1;
               if (wcnt_ff[2:0] == 3'd0) begin
                  rcon_in = xtime(rcon_ff);
               end
            end
         end
         ST_IDLE: begin
            if (rerun_ff) begin
               rerun_in = csr_valid;
               win_in   = key_ff;
               wcnt_in  = 6'd8;
               rcon_in  = RCON_1;
               state_in = ST_EXPAND;
            end else if (req_valid && req_ready) begin
               dec_in   = req_word.req_type;
               st_in    = {req_word.block_high, req_word.block_low};
               rd_addr  = (req_word.req_type == OP_DECRYPT) ? 4'd14 : 4'd0;
               rnd_in   = (req_word.req_type == OP_DECRYPT) ? 4'd14 : 4'd0;
               state_in = ST_PRIME;
            end
         end
         ST_PRIME: begin
            st_in    = st_ff ^ rk;
            rd_addr  = dec_ff ? rnd_ff - 4'd1 : rnd_ff + 4'd1;
            rnd_in   = rd_addr;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            // last round waits while the previous result word is still held
            if (!(last && out_v_ff && !rsp_ready)) begin
               st_in   = rnd_out;
               rd_addr = dec_ff ? rnd_ff - 4'd1 : rnd_ff + 4'd1;
               rnd_in  = rd_addr;
               if (last) begin
                  out_v_in = 1'b1;
                  out_in   = rnd_out;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         key_ff   <= '0;
         rerun_ff <= 1'b1;
         out_v_ff <= 1'b0;
         wcnt_ff  <= '0;
         rcon_ff  <= RCON_1;
         rnd_ff   <= '0;
         dec_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         key_ff   <= key_in;
         rerun_ff <= rerun_in;
         out_v_ff <= out_v_in;
         wcnt_ff  <= wcnt_in;
         rcon_ff  <= rcon_in;
         rnd_ff   <= rnd_in;
         dec_ff   <= dec_in;
      end
      win_ff <= win_in;
      st_ff  <= st_in;
      out_ff <= out_in;
   end

endmodule

### hdl/aes256_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes256_ram
// generic single-port-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module aes256_ram #(
   parameter int Width = 128,
   parameter int Depth = 15
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the aes-256 ecb core. a directed table (known
// vectors, extreme blocks and keys) is followed by random blocks under
// three handshake idling mixes and several keys. every result word is
// compared with its table vector or an in-bench aes-256 model holding its own round keys.
// ----------------------------------------------------------------------------
module tb_top;
   import aes256_pkg::*;

   localparam int ITEMS_PER_PHASE = 290;
   localparam int DRAIN_CYCLES    = 40;
   localparam int STALL_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT  = 4000;

   typedef struct {
      int          key_id;
      logic        op;
      logic [63:0] hi;
      logic [63:0] lo;
      bit          known;
      logic [127:0] want;
   } cipher_row_type;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_word_type rsp_word;
   logic         csr_valid;
   logic         csr_ready;
   logic [1:0]   csr_index;
   logic [63:0]  csr_data;

   logic [127:0] round_keys [15];
   logic [63:0]  key_regs [4];
   rsp_word_type result_q [$];

   int fail_count;
   int send_idle_pct;
   int recv_idle_pct;
   int stall_token;
   int stall_seen;
   int stall_left;
   int quiet_cycles;

   logic [63:0] key_sets [4][4] = '{
      '{64'h0, 64'h0, 64'h0, 64'h0},
      '{64'h0001020304050607, 64'h08090a0b0c0d0e0f,
        64'h1011121314151617, 64'h18191a1b1c1d1e1f},
      '{64'hffffffffffffffff, 64'hffffffffffffffff,
        64'hffffffffffffffff, 64'hffffffffffffffff},
      '{64'h8000000000000000, 64'h0, 64'h0, 64'h0000000000000001}
   };

   cipher_row_type directed [] = '{
      '{0, OP_ENCRYPT, 64'h0, 64'h0, 1, 128'hdc95c078a2408989ad48a21492842087},
      '{0, OP_DECRYPT, 64'hdc95c078a2408989, 64'had48a21492842087, 1, 128'h0},
      '{0, OP_ENCRYPT, 64'hffffffffffffffff, 64'hffffffffffffffff, 0, 128'h0},
      '{0, OP_DECRYPT, 64'hffffffffffffffff, 64'hffffffffffffffff, 0, 128'h0},
      '{0, OP_ENCRYPT, 64'h8000000000000000, 64'h0000000000000001, 0, 128'h0},
      '{1, OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff, 1,
        128'h8ea2b7ca516745bfeafc49904b496089},
      '{1, OP_DECRYPT, 64'h8ea2b7ca516745bf, 64'heafc49904b496089, 1,
        128'h00112233445566778899aabbccddeeff},
      '{1, OP_ENCRYPT, 64'h0, 64'hffffffffffffffff, 0, 128'h0},
      '{1, OP_DECRYPT, 64'hffffffffffffffff, 64'h0, 0, 128'h0},
      '{2, OP_ENCRYPT, 64'h0, 64'h0, 0, 128'h0},
      '{2, OP_DECRYPT, 64'h0, 64'h0, 0, 128'h0},
      '{2, OP_ENCRYPT, 64'hffffffffffffffff, 64'hffffffffffffffff, 0, 128'h0},
      '{3, OP_ENCRYPT, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 0, 128'h0},
      '{3, OP_DECRYPT, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 0, 128'h0}
   };

   aes256_block_cipher_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] gf_double(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p = p ^ a;
         a = gf_double(a);
      end
      return p;
   endfunction

   function automatic void expand_round_keys();
      logic [7:0] w [240];
      logic [7:0] t [4];
      logic [7:0] tmp;
      logic [7:0] rcon;
      rcon = 8'h01;
      for (int i = 0; i < 32; i++) w[i] = key_regs[i / 8][63 - 8 * (i % 8) -: 8];
      for (int i = 8; i < 60; i++) begin
         for (int k = 0; k < 4; k++) t[k] = w[(i - 1) * 4 + k];
         if (i % 8 == 0) begin
            tmp = t[0]; t[0] = t[1]; t[1] = t[2]; t[2] = t[3]; t[3] = tmp;
            for (int k = 0; k < 4; k++) t[k] = SBOX[t[k]];
            t[0] = t[0] ^ rcon;
            rcon = gf_double(rcon);
         end else if (i % 8 == 4) begin
            for (int k = 0; k < 4; k++) t[k] = SBOX[t[k]];
         end
         for (int k = 0; k < 4; k++) w[i * 4 + k] = w[(i - 8) * 4 + k] ^ t[k];
      end
      for (int r = 0; r < 15; r++)
         for (int i = 0; i < 16; i++) round_keys[r][127 - 8 * i -: 8] = w[r * 16 + i];
   endfunction

   function automatic logic [127:0] aes_predict(input logic op, input logic [127:0] blk);
      logic [7:0] s [16];
      logic [7:0] o [16];
      logic [7:0] acc;
      logic [7:0] fwd [4];
      logic [7:0] inv [4];
      logic [127:0] res;
      fwd = '{8'h02, 8'h03, 8'h01, 8'h01};
      inv = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
      for (int i = 0; i < 16; i++) s[i] = blk[127 - 8 * i -: 8];
      for (int n = 0; n < 15; n++) begin
         int r;
         r = (op == OP_DECRYPT) ? 14 - n : n;
         if (n > 0) begin
            for (int c = 0; c < 4; c++)
               for (int w = 0; w < 4; w++) begin
                  if (op == OP_DECRYPT) o[((c + w) & 3) * 4 + w] = INV_SBOX[s[c * 4 + w]];
                  else o[c * 4 + w] = SBOX[s[((c + w) & 3) * 4 + w]];
               end
            s = o;
            if (op == OP_ENCRYPT && n < 14) begin
               for (int c = 0; c < 4; c++)
                  for (int w = 0; w < 4; w++) begin
                     acc = 8'h00;
                     for (int k = 0; k < 4; k++)
                        acc = acc ^ gf_mult(s[c * 4 + k], fwd[(k - w) & 3]);
                     o[c * 4 + w] = acc;
                  end
               s = o;
            end
         end
         for (int i = 0; i < 16; i++) s[i] = s[i] ^ round_keys[r][127 - 8 * i -: 8];
         if (op == OP_DECRYPT && n > 0 && n < 14) begin
            for (int c = 0; c < 4; c++)
               for (int w = 0; w < 4; w++) begin
                  acc = 8'h00;
                  for (int k = 0; k < 4; k++)
                     acc = acc ^ gf_mult(s[c * 4 + k], inv[(k - w) & 3]);
                  o[c * 4 + w] = acc;
               end
            s = o;
         end
      end
      for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = s[i];
      return res;
   endfunction

   // result checker
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (result_q.size() == 0) begin
            $error("result word with none expected: %h", rsp_word);
            fail_count++;
         end else begin
            want = result_q.pop_front();
            if (rsp_word.out_high !== want.out_high) begin
               $error("out_high expected %h actual %h", want.out_high, rsp_word.out_high);
               fail_count++;
            end
            if (rsp_word.out_low !== want.out_low) begin
               $error("out_low expected %h actual %h", want.out_low, rsp_word.out_low);
               fail_count++;
            end
         end
      end
   end

   // receiver, with long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      stall_seen = 0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_token != stall_seen) begin
            stall_seen = stall_token;
            stall_left = STALL_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic wait_drained();
      while (result_q.size() != 0) @(negedge clock);
   endtask

   task automatic load_key(input logic [63:0] k [4]);
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      for (int i = 0; i < 4; i++) begin
         if (i > 0) @(negedge clock);
         csr_valid <= 1'b1;
         csr_index <= i[1:0];
         csr_data  <= k[i];
         do @(posedge clock); while (!csr_ready);
         key_regs[i] = k[i];
         expand_round_keys();
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic issue_block(input logic op, input logic [63:0] hi, input logic [63:0] lo,
                              input bit known, input logic [127:0] want);
      int gap;
      rsp_word_type res;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 60) gap++;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_word  <= '{req_type: op, block_high: hi, block_low: lo};
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      res = known ? want : aes_predict(op, {hi, lo});
      result_q.push_back(res);
   endtask

   function automatic logic [63:0] rand_half();
      case ($urandom_range(9))
         0: return 64'h0;
         1: return '1;
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   initial begin
      int cur_key;
      logic [63:0] k [4];
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      csr_valid = 1'b0;
      csr_index = CSR_KEY_0_7;
      csr_data = '0;
      fail_count = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stall_token = 0;
      quiet_cycles = 0;
      key_regs = '{64'h0, 64'h0, 64'h0, 64'h0};
      expand_round_keys();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      cur_key = 0;
      foreach (directed[i]) begin
         if (directed[i].key_id != cur_key) begin
            cur_key = directed[i].key_id;
            @(negedge clock);
            req_valid <= 1'b0;
            load_key(key_sets[cur_key]);
         end
         issue_block(directed[i].op, directed[i].hi, directed[i].lo,
                     directed[i].known, directed[i].want);
      end

      // random blocks, two keys per idling mix
      for (int phase = 0; phase < 6; phase++) begin
         send_idle_pct = (phase < 2) ? 37 : (phase < 4) ? 63 : 0;
         recv_idle_pct = (phase < 2) ? 63 : (phase < 4) ? 37 : 0;
         if (phase == 3) k = key_sets[2];
         else for (int j = 0; j < 4; j++) k[j] = rand_half();
         @(negedge clock);
         req_valid <= 1'b0;
         load_key(k);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (phase == 4 && n == 20) stall_token++;
            if (phase == 4 && n == 40) begin
               @(negedge clock);
               req_valid <= 1'b0;
               wait_drained();
            end
            issue_block(logic'($urandom_range(1)), rand_half(), rand_half(), 0, '0);
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
